@@ src/rltr_pkg.sv @@
// shared widths, codes and types of the rate limited trace ring
// used by the time table, the ring memory, the top level and the bench
package rltr_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int CPU_SLOTS_DEF  = 256;

  localparam int KIND_W      = 2;
  localparam int TS_W        = 64;
  localparam int REASON_W    = 32;
  localparam int CPU_W       = 12;
  localparam int RIDX_W      = 10;
  localparam int CNT_W       = 63;
  localparam int STORED_W    = 11;
  localparam int DELTA_W     = 32;
  localparam int CAP_FIELD_W = 11;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 120;

  // command kinds carried on s_tuser
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_PEEK  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_DELTA = 1'b0,
    REG_CAPACITY   = 1'b1
  } reg_idx_t;

  // one ring slot
  typedef struct packed {
    logic [CPU_W-1:0]    cpu;
    logic [REASON_W-1:0] reason;
    logic [TS_W-1:0]     ts;
  } ring_entry_t;

  // time table port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } tt_ctrl_t;

  // ring memory port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctrl_t;

endpackage

@@ src/rate_limited_trace_ring_top.sv @@
// top level of the rate limited trace ring: control, counters, result register
// depends on rltr_pkg, rltr_time_table and rltr_ring_mem
//
// usage
//   s_* channel: one transfer per command; s_tuser is the kind (push, peek,
//     clear), s_tdata the event fields. m_* channel: one result transfer per
//     command, in command order. cfg_we/cfg_index/cfg_data write the rate
//     limit delta (index 0) and the capacity in use (index 1, clamped to
//     1..RING_DEPTH); write them only while the block is idle.
// sequence
//   an input transfer moves the block to the slot state (slot reduction of the
//   cpu number plus memory read), then to the execute state (compute, write
//   back, result register). one command is in work at a time, so no new command
//   is taken until execute finishes the read-modify-write of table and ring.
// reset and clear
//   rst clears counters, pointer and fill mark at once and the block takes
//   a command in the next cycle; no memory sweep is run. the last-time table
//   uses per-entry valid bits, the ring a fill mark (slots below it were
//   written since clear, all others read as zero).
// stall
//   the result sits in an output register; the next command is taken while
//   it waits, and that command's write back waits until the register frees.
module rate_limited_trace_ring_top #(
  parameter int RING_DEPTH = rltr_pkg::RING_DEPTH_DEF,
  parameter int CPU_SLOTS  = rltr_pkg::CPU_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // timestamp, exit_reason, cpu_number, read_index, 2 pad bits
  input  logic [rltr_pkg::IN_DATA_W-1:0] s_tdata,
  // kind
  input  logic [rltr_pkg::KIND_W-1:0]    s_tuser,
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // accepted, rate_dropped, overwrote, total_pushed, stored_count,
  // rate_drop_count, overwrite_count, peek_time, peek_reason, peek_cpu, status
  output logic [311:0]                   m_tdata,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [rltr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rltr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rltr_pkg::*;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int CAP_W  = $clog2(RING_DEPTH + 1);
  localparam int SLOT_W = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
  // cpu mod CPU_SLOTS by exact reciprocal for CPU_W-bit numerators
  localparam int MOD_SH  = CPU_W + $clog2(CPU_SLOTS);
  localparam int MOD_MUL = ((1 << MOD_SH) + CPU_SLOTS - 1) / CPU_SLOTS;
  localparam int MUL_W   = CPU_W + 2;
  localparam int PROD_W  = CPU_W + MUL_W;
  localparam int REM_W   = CPU_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // accepted, the last field, in the lowest bits
  typedef struct packed {
    logic                status;
    logic [CPU_W-1:0]    peek_cpu;
    logic [REASON_W-1:0] peek_reason;
    logic [TS_W-1:0]     peek_time;
    logic [CNT_W-1:0]    overwrite_count;
    logic [CNT_W-1:0]    rate_drop_count;
    logic [STORED_W-1:0] stored_count;
    logic [CNT_W-1:0]    total_pushed;
    logic                overwrote;
    logic                rate_dropped;
    logic                accepted;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_EXEC
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  state_t               state;
  result_t              result_q;
  result_t              res;

  // config registers
  logic [DELTA_W-1:0]   delta;
  logic [CAP_W-1:0]     cap;
  logic [CFG_DATA_W-1:0] cap_raw;
  logic [CFG_DATA_W-1:0] cap_clamped;

  // control state
  logic [PTR_W-1:0]     wp;
  logic [CAP_W-1:0]     fill;
  logic [CNT_W-1:0]     pushed;
  logic [CNT_W-1:0]     drops;
  logic [CNT_W-1:0]     overwrites;

  // captured command
  kind_t                kind_q;
  logic [TS_W-1:0]      ts_q;
  logic [REASON_W-1:0]  reason_q;
  logic [CPU_W-1:0]     cpu_q;
  logic [RIDX_W-1:0]    ridx_q;
  logic [CPU_W-1:0]     quo_q;
  logic [SLOT_W-1:0]    slot_q;

  logic [PROD_W-1:0]    prod;
  logic [REM_W-1:0]     rem;
  logic [SLOT_W-1:0]    slot;
  logic [31:0]          ridx_wide;

  // execute stage
  logic                 exec_go;
  logic                 in_xfer;
  logic [TS_W-1:0]      last;
  logic [TS_W-1:0]      elapsed;
  logic                 limited;
  logic                 full;
  logic [CAP_W-1:0]     wp_ext;
  logic [CAP_W-1:0]     wp_use;
  logic [CAP_W-1:0]     wp_inc;
  logic [CAP_W-1:0]     wp_wrap;
  logic [CAP_W-1:0]     fill_bump;
  logic                 peek_oor;
  logic                 peek_hit;
  logic [CNT_W-1:0]     pushed_p1;
  logic                 do_store;
  logic                 do_clear;
  logic [PTR_W-1:0]     wp_next;
  logic [CAP_W-1:0]     fill_next;
  logic [CNT_W-1:0]     pushed_next;
  logic [CNT_W-1:0]     drops_next;
  logic [CNT_W-1:0]     overwrites_next;

  tt_ctrl_t             tt_ctrl;
  logic [TS_W-1:0]      tt_rd_data;
  ring_ctrl_t           ring_ctrl;
  ring_entry_t          ring_wr_data;
  ring_entry_t          ring_rd_data;

  // nothing is taken while reset is held
  assign s_tready = (state == ST_IDLE) && !rst;
  assign in_xfer  = s_tvalid && s_tready;
  assign exec_go  = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign m_tdata  = result_q;

  // capacity clamp at write time
  assign cap_raw     = CFG_DATA_W'(cfg_data[CAP_FIELD_W-1:0]);
  assign cap_clamped = (cap_raw == '0) ? CFG_DATA_W'(1) :
                       (cap_raw > CFG_DATA_W'(RING_DEPTH)) ? CFG_DATA_W'(RING_DEPTH) :
                       cap_raw;

  // quotient of the cpu number, registered before the back multiply
  assign prod = PROD_W'(s_tdata[TS_W+REASON_W +: CPU_W]) * PROD_W'(MOD_MUL);
  assign rem  = REM_W'(cpu_q) - REM_W'(quo_q) * REM_W'(CPU_SLOTS);
  assign slot = rem[SLOT_W-1:0];
  assign ridx_wide = 32'(ridx_q);

  // memory controls
  assign tt_ctrl.rd_en   = (state == ST_SLOT);
  assign tt_ctrl.wr_en   = do_store;
  assign tt_ctrl.clear   = do_clear;
  assign ring_ctrl.rd_en = (state == ST_SLOT);
  assign ring_ctrl.wr_en = do_store;
  assign ring_wr_data    = '{cpu: cpu_q, reason: reason_q, ts: ts_q};

  rltr_time_table #(
    .CPU_SLOTS(CPU_SLOTS)
  ) u_time_table (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tt_ctrl),
    .rd_addr (slot),
    .wr_addr (slot_q),
    .wr_data (ts_q),
    .rd_data (tt_rd_data)
  );

  rltr_ring_mem #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring_mem (
    .clk     (clk),
    .ctrl    (ring_ctrl),
    .rd_addr (ridx_wide[PTR_W-1:0]),
    .wr_addr (wp_use[PTR_W-1:0]),
    .wr_data (ring_wr_data),
    .rd_data (ring_rd_data)
  );

  // rate check, pointer wrap and fill mark
  always_comb begin
    last      = tt_rd_data;
    elapsed   = ts_q - last;
    limited   = (delta != '0) && (last != '0) && (elapsed < TS_W'(delta));
    full      = (pushed >= CNT_W'(cap));
    wp_ext    = CAP_W'(wp);
    wp_use    = (wp_ext >= cap) ? '0 : wp_ext;
    wp_inc    = wp_use + 1'b1;
    wp_wrap   = (wp_inc >= cap) ? '0 : wp_inc;
    fill_bump = (wp_inc > fill) ? wp_inc : fill;
    peek_oor  = (32'(ridx_q) >= 32'(cap));
    peek_hit  = !peek_oor && (32'(ridx_q) < 32'(fill));
    pushed_p1 = pushed + 1'b1;
  end

  // result and next counter values of the command in the execute stage
  always_comb begin
    do_store        = 1'b0;
    do_clear        = 1'b0;
    wp_next         = wp;
    fill_next       = fill;
    pushed_next     = pushed;
    drops_next      = drops;
    overwrites_next = overwrites;
    res             = '0;
    res.stored_count = full ? STORED_W'(cap) : STORED_W'(pushed);
    unique case (kind_q)
      KIND_PUSH: begin
        if (limited) begin
          drops_next       = sat_inc(drops);
          res.rate_dropped = 1'b1;
        end else begin
          do_store         = exec_go;
          overwrites_next  = full ? sat_inc(overwrites) : overwrites;
          pushed_next      = sat_inc(pushed);
          wp_next          = wp_wrap[PTR_W-1:0];
          fill_next        = fill_bump;
          res.accepted     = 1'b1;
          res.overwrote    = full;
          // pushed below cap means pushed plus one is at most cap
          res.stored_count = full ? STORED_W'(cap) : STORED_W'(pushed_p1);
        end
      end
      KIND_PEEK: begin
        res.status = peek_oor;
        if (peek_hit) begin
          res.peek_time   = ring_rd_data.ts;
          res.peek_reason = ring_rd_data.reason;
          res.peek_cpu    = ring_rd_data.cpu;
        end
      end
      KIND_CLEAR: begin
        do_clear         = exec_go;
        wp_next          = '0;
        fill_next        = '0;
        pushed_next      = '0;
        drops_next       = '0;
        overwrites_next  = '0;
        res.stored_count = '0;
      end
      default: begin
        // unused kind: counters only
      end
    endcase
    res.total_pushed    = pushed_next;
    res.rate_drop_count = drops_next;
    res.overwrite_count = overwrites_next;
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_q   <= kind_t'(s_tuser);
      ts_q     <= s_tdata[TS_W-1:0];
      reason_q <= s_tdata[TS_W +: REASON_W];
      cpu_q    <= s_tdata[TS_W+REASON_W +: CPU_W];
      ridx_q   <= s_tdata[TS_W+REASON_W+CPU_W +: RIDX_W];
      quo_q    <= CPU_W'(prod >> MOD_SH);
    end
    if (state == ST_SLOT) begin
      slot_q <= slot;
    end
  end

  // sequencer, counters, config and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      wp         <= '0;
      fill       <= '0;
      pushed     <= '0;
      drops      <= '0;
      overwrites <= '0;
      delta      <= '0;
      cap        <= CAP_W'(RING_DEPTH);
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_SLOT;
          end
        end
        ST_SLOT: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (exec_go) begin
        m_tvalid   <= 1'b1;
        result_q   <= res;
        wp         <= wp_next;
        fill       <= fill_next;
        pushed     <= pushed_next;
        drops      <= drops_next;
        overwrites <= overwrites_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_RATE_DELTA: delta <= cfg_data[DELTA_W-1:0];
          REG_CAPACITY:   cap   <= cap_clamped[CAP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // a finished command always lands in the result register and frees the input
  a_exec_handoff: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> (state == ST_IDLE) && m_tvalid)
    else $error("execute stage did not hand over its result");

  // a push is either stored or dropped, never both
  a_push_outcome: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(result_q.accepted && result_q.rate_dropped))
    else $error("push both stored and dropped");

  // stored count never runs ahead of the pushed total
  a_stored_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CNT_W'(result_q.stored_count) <= result_q.total_pushed))
    else $error("stored count above pushed total");

  // fill mark stays within the ring
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    exec_go |=> (32'(fill) <= RING_DEPTH))
    else $error("fill mark beyond ring depth");

endmodule

@@ src/rltr_time_table.sv @@
// per-slot last-time table: one synchronous memory with registered read
// valid bits per entry give the cleared value of zero; depends on rltr_pkg
module rltr_time_table #(
  parameter int CPU_SLOTS = rltr_pkg::CPU_SLOTS_DEF,
  localparam int SLOT_W = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rltr_pkg::tt_ctrl_t       ctrl,
  input  logic [SLOT_W-1:0]        rd_addr,
  input  logic [SLOT_W-1:0]        wr_addr,
  input  logic [rltr_pkg::TS_W-1:0] wr_data,
  output logic [rltr_pkg::TS_W-1:0] rd_data
);
  import rltr_pkg::*;

  logic [TS_W-1:0]      mem [CPU_SLOTS];
  logic [CPU_SLOTS-1:0] vld;
  logic [TS_W-1:0]      mem_q;
  logic                 vld_q;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      vld <= '0;
    end else if (ctrl.wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
    if (rst) begin
      vld_q <= 1'b0;
    end else if (ctrl.rd_en) begin
      vld_q <= vld[rd_addr];
    end
  end

  // never-written entry reads as zero
  assign rd_data = vld_q ? mem_q : '0;

endmodule

@@ src/rltr_ring_mem.sv @@
// ring slot storage: one synchronous memory, one write and one read port
// read data registered and held between reads; depends on rltr_pkg
module rltr_ring_mem #(
  parameter int RING_DEPTH = rltr_pkg::RING_DEPTH_DEF,
  localparam int PTR_W = $clog2(RING_DEPTH)
) (
  input  logic                  clk,
  input  rltr_pkg::ring_ctrl_t  ctrl,
  input  logic [PTR_W-1:0]      rd_addr,
  input  logic [PTR_W-1:0]      wr_addr,
  input  rltr_pkg::ring_entry_t wr_data,
  output rltr_pkg::ring_entry_t rd_data
);
  import rltr_pkg::*;

  ring_entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ verif/tb_top.sv @@
// self-checking bench for rate_limited_trace_ring_top: directed table, then random phases
// depends on rltr_pkg for widths, command and register codes and the ring_entry_t slot type
// every result transfer is compared against an in-bench predictor of the trace ring or a fixed golden row
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rltr_pkg::*;

  localparam int RING_N      = RING_DEPTH_DEF;
  localparam int CPU_N       = CPU_SLOTS_DEF;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 118;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // s_tdata layout, lowest field last
  typedef struct packed {
    logic [1:0]          pad;
    logic [RIDX_W-1:0]   read_index;
    logic [CPU_W-1:0]    cpu;
    logic [REASON_W-1:0] reason;
    logic [TS_W-1:0]     ts;
  } trace_fields_t;

  typedef struct packed {
    kind_t         kind;
    trace_fields_t f;
  } trace_cmd_t;

  // m_tdata layout, accepted in bit 0 up to status in bit 311
  typedef struct packed {
    logic                status;
    logic [CPU_W-1:0]    peek_cpu;
    logic [REASON_W-1:0] peek_reason;
    logic [TS_W-1:0]     peek_time;
    logic [CNT_W-1:0]    overwrite_count;
    logic [CNT_W-1:0]    rate_drop_count;
    logic [STORED_W-1:0] stored_count;
    logic [CNT_W-1:0]    total_pushed;
    logic                overwrote;
    logic                rate_dropped;
    logic                accepted;
  } trace_result_t;

  // one row of the directed table: a register write or a command
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    trace_cmd_t            cmd;
    logic                  typed;
    trace_result_t         golden;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [KIND_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [311:0] m_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rate_limited_trace_ring_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the trace ring state
  logic [TS_W-1:0]      shadow_last [CPU_N];
  ring_entry_t          shadow_ring [RING_N];
  int unsigned          wr_ptr;
  logic [CNT_W-1:0]     n_pushed;
  logic [CNT_W-1:0]     n_rate_drop;
  logic [CNT_W-1:0]     n_overwrite;
  logic [DELTA_W-1:0]   cur_delta;
  logic [CAP_FIELD_W-1:0] cur_cap;

  trace_result_t pending_results [$];
  stim_row_t     dir_rows [$];
  int            mismatch_cnt = 0;
  int            n_results = 0;
  bit            idle_on = 1'b0;   // random gaps on both sides
  bit            hold_req = 1'b0;  // asks the sink for one long hold-off
  logic [TS_W-1:0] sim_now;        // running event time for random pushes

  // capacity as the ring uses it: zero acts as one, large values clip to depth
  function automatic int unsigned cap_in_effect();
    if (cur_cap == '0) return 1;
    if (cur_cap > RING_N) return RING_N;
    return cur_cap;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

  // clear keeps the registers, only ring, counters and time table go
  function automatic void wipe_shadow();
    foreach (shadow_last[i]) shadow_last[i] = '0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    wr_ptr = 0;
    n_pushed = '0;
    n_rate_drop = '0;
    n_overwrite = '0;
  endfunction

  // applies one command to the shadow state and returns the result it gives
  function automatic trace_result_t trace_step(trace_cmd_t c);
    trace_result_t r;
    int unsigned cap;
    int unsigned slot;
    r = '0;
    cap = cap_in_effect();
    case (c.kind)
      KIND_PUSH: begin
        slot = c.f.cpu % CPU_N;
        // elapsed time wraps mod 2^64; a zero last time means no prior event
        if (cur_delta != '0 && shadow_last[slot] != '0 &&
            (c.f.ts - shadow_last[slot]) < {32'd0, cur_delta}) begin
          n_rate_drop = sat_inc(n_rate_drop);
          r.rate_dropped = 1'b1;
        end else begin
          shadow_last[slot] = c.f.ts;
          if (n_pushed >= cap) begin
            n_overwrite = sat_inc(n_overwrite);
            r.overwrote = 1'b1;
          end
          n_pushed = sat_inc(n_pushed);
          // capacity may have shrunk under the pointer
          if (wr_ptr >= cap) wr_ptr = 0;
          shadow_ring[wr_ptr].ts = c.f.ts;
          shadow_ring[wr_ptr].reason = c.f.reason;
          shadow_ring[wr_ptr].cpu = c.f.cpu;
          wr_ptr++;
          if (wr_ptr >= cap) wr_ptr = 0;
          r.accepted = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (c.f.read_index >= cap) begin
          r.status = 1'b1;
        end else begin
          r.peek_time = shadow_ring[c.f.read_index].ts;
          r.peek_reason = shadow_ring[c.f.read_index].reason;
          r.peek_cpu = shadow_ring[c.f.read_index].cpu;
        end
      end
      KIND_CLEAR: begin
        wipe_shadow();
      end
      default: begin
      end
    endcase
    r.total_pushed = n_pushed;
    r.stored_count = (n_pushed < cap) ? STORED_W'(n_pushed) : STORED_W'(cap);
    r.rate_drop_count = n_rate_drop;
    r.overwrite_count = n_overwrite;
    return r;
  endfunction

  // random command: mostly pushes on a few colliding cpu slots with a
  // slowly advancing clock, so the rate limit both passes and drops
  function automatic trace_cmd_t random_cmd();
    trace_cmd_t c;
    int unsigned pick;
    c = '0;
    c.f.ts = {$urandom, $urandom};
    c.f.reason = $urandom;
    c.f.cpu = CPU_W'($urandom_range(0, 4095));
    c.f.read_index = RIDX_W'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      c.kind = KIND_PUSH;
      sim_now = sim_now + $urandom_range(0, 24);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        c.f.ts = '0;
      end else if (pick > 1) begin
        c.f.ts = sim_now;
      end
      // same slot reached from different upper cpu bits
      if ($urandom_range(0, 9) < 7) begin
        c.f.cpu = {4'($urandom_range(0, 15)),
                   ($urandom_range(0, 3) == 3) ? 8'hFF : 8'($urandom_range(0, 2))};
      end
    end else if (pick < 94) begin
      c.kind = KIND_PEEK;
      // mostly in range, sometimes just past the capacity
      if ($urandom_range(0, 9) < 7) c.f.read_index = RIDX_W'($urandom_range(0, cap_in_effect()));
    end else if (pick < 97) begin
      c.kind = KIND_CLEAR;
    end else begin
      c.kind = KIND_NONE;
    end
    return c;
  endfunction

  function automatic void add_cmd(kind_t k, logic [TS_W-1:0] ts,
                                  logic [REASON_W-1:0] rsn, logic [CPU_W-1:0] cpu,
                                  logic [RIDX_W-1:0] idx, logic typed,
                                  trace_result_t golden);
    stim_row_t r;
    r = '0;
    r.cmd.kind = k;
    r.cmd.f.ts = ts;
    r.cmd.f.reason = rsn;
    r.cmd.f.cpu = cpu;
    r.cmd.f.read_index = idx;
    r.typed = typed;
    r.golden = golden;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = v;
    dir_rows.push_back(r);
  endfunction

  function automatic string field_diffs(trace_result_t a, trace_result_t b);
    string s;
    s = "";
    if (a.accepted !== b.accepted) s = {s, " accepted"};
    if (a.rate_dropped !== b.rate_dropped) s = {s, " rate_dropped"};
    if (a.overwrote !== b.overwrote) s = {s, " overwrote"};
    if (a.total_pushed !== b.total_pushed) s = {s, " total_pushed"};
    if (a.stored_count !== b.stored_count) s = {s, " stored_count"};
    if (a.rate_drop_count !== b.rate_drop_count) s = {s, " rate_drop_count"};
    if (a.overwrite_count !== b.overwrite_count) s = {s, " overwrite_count"};
    if (a.peek_time !== b.peek_time) s = {s, " peek_time"};
    if (a.peek_reason !== b.peek_reason) s = {s, " peek_reason"};
    if (a.peek_cpu !== b.peek_cpu) s = {s, " peek_cpu"};
    if (a.status !== b.status) s = {s, " status"};
    return s;
  endfunction

  function automatic void note_failure(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endfunction

  // offers one command, starting and ending at a falling edge; valid stays
  // high on return so back-to-back commands need no gap
  task automatic send_cmd(trace_cmd_t c, logic typed, trace_result_t golden);
    trace_result_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c.f;
    s_tuser <= c.kind;
    do @(posedge clk); while (!s_tready);
    // transfer taken at this edge, so the predictor steps now
    res = trace_step(c);
    pending_results.push_back(typed ? golden : res);
    @(negedge clk);
  endtask

  // stop offering and wait until every expected result has been seen
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    if (idx == REG_CAPACITY) cur_cap = v[CAP_FIELD_W-1:0];
    else cur_delta = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk) begin : result_check
    trace_result_t got;
    trace_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = trace_result_t'(m_tdata);
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result %0d with nothing expected: got %h", n_results, got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          note_failure($sformatf("result %0d mismatch in%s\n  exp %h\n  got %h",
                                 n_results, field_diffs(want, got), want, got));
      end
      n_results++;
    end
  end

  // result sink: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // run limit, far above the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    trace_result_t g_zero;
    trace_result_t g_first;
    trace_result_t g_second;
    logic [CAP_FIELD_W-1:0] phase_cap [N_PHASES];
    logic [DELTA_W-1:0] phase_delta [N_PHASES];

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sim_now = 64'd1000;
    wipe_shadow();
    cur_delta = '0;
    cur_cap = CAP_FIELD_W'(RING_N);

    // results that are plain from the reset state
    g_zero = '0;
    g_first = '0;
    g_first.accepted = 1'b1;
    g_first.total_pushed = 1;
    g_first.stored_count = 1;
    g_second = g_first;
    g_second.total_pushed = 2;
    g_second.stored_count = 2;

    // directed table
    // fresh ring: empty slots read as zero, unused kind and clear touch nothing
    add_cmd(KIND_PEEK, '0, '0, '0, 10'd0, 1'b1, g_zero);
    add_cmd(KIND_PEEK, '1, '1, '1, 10'd1023, 1'b1, g_zero);
    add_cmd(KIND_NONE, '1, '1, '1, '1, 1'b1, g_zero);
    add_cmd(KIND_CLEAR, '0, '0, '0, '0, 1'b1, g_zero);
    // extremes of the event fields; timestamp zero leaves slot 255 unmarked
    add_cmd(KIND_PUSH, '0, '1, 12'hFFF, '0, 1'b1, g_first);
    add_cmd(KIND_PUSH, '1, '0, 12'h000, '1, 1'b1, g_second);
    add_cfg(REG_RATE_DELTA, 32'd100);
    add_cfg(REG_CAPACITY, 32'd4);
    add_cmd(KIND_PUSH, 64'd10, 32'h1111_0001, 12'h0FF, '0, 1'b0, g_zero);
    add_cmd(KIND_PUSH, 64'd50, 32'h1111_0002, 12'h1FF, '0, 1'b0, g_zero);
    // elapsed time wraps past 2^64 and is small, so dropped
    add_cmd(KIND_PUSH, 64'd5, 32'h1111_0003, 12'h000, '0, 1'b0, g_zero);
    add_cmd(KIND_PUSH, 64'd200, 32'h1111_0004, 12'h100, '0, 1'b0, g_zero);
    // exactly delta apart passes, and the ring is full so it overwrites
    add_cmd(KIND_PUSH, 64'd300, 32'h1111_0005, 12'hA00, '0, 1'b0, g_zero);
    add_cmd(KIND_PEEK, '0, '0, '0, 10'd3, 1'b0, g_zero);
    add_cmd(KIND_PEEK, '0, '0, '0, 10'd4, 1'b0, g_zero);
    // capacity zero acts as one slot, widest delta
    add_cfg(REG_RATE_DELTA, 32'hFFFF_FFFF);
    add_cfg(REG_CAPACITY, 32'd0);
    add_cmd(KIND_PUSH, 64'd1000, 32'h2222_0001, 12'h007, '0, 1'b0, g_zero);
    add_cmd(KIND_PUSH, 64'd2000, 32'h2222_0002, 12'h807, '0, 1'b0, g_zero);
    add_cmd(KIND_PEEK, '0, '0, '0, 10'd0, 1'b0, g_zero);
    add_cmd(KIND_PEEK, '0, '0, '0, 10'd1, 1'b0, g_zero);
    // capacity above depth clips, limiting off
    add_cfg(REG_RATE_DELTA, 32'd0);
    add_cfg(REG_CAPACITY, 32'd2047);
    add_cmd(KIND_PUSH, 64'd2001, 32'h3333_0001, 12'h007, '0, 1'b0, g_zero);
    add_cmd(KIND_PEEK, '0, '0, '0, 10'd1, 1'b0, g_zero);
    add_cmd(KIND_PEEK, '0, '0, '0, 10'd1023, 1'b0, g_zero);
    add_cmd(KIND_CLEAR, '0, '0, '0, '0, 1'b1, g_zero);
    add_cmd(KIND_PEEK, '0, '0, '0, 10'd0, 1'b1, g_zero);

    // per-phase settings for the random part
    phase_cap = '{11'd3, 11'd1, 11'd0, 11'd16, 11'd1024, 11'd2047, 11'd7, 11'd2};
    phase_delta = '{32'd25, 32'd0, 32'hFFFF_FFFF, 32'd40, 32'd12, 32'd1, 32'd60, 32'd30};
    phase_cap[6] = CAP_FIELD_W'($urandom_range(1, 64));
    phase_delta[6] = $urandom_range(1, 80);

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_on = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].golden);
      end
    end

    // random phases; registers change only once the ring has gone quiet,
    // with no clear in between, so capacity shrinks under a live pointer
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_reg(REG_RATE_DELTA, phase_delta[p]);
      write_reg(REG_CAPACITY, {21'd0, phase_cap[p]});
      // final phase runs at full rate on both sides
      idle_on = (p != N_PHASES - 1);
      // event clock about to wrap past 2^64
      if (p == 3) sim_now = 64'hFFFF_FFFF_FFFF_FE00;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long sink hold-off while commands keep coming, to back up the input
        if (p == 1 && n == 30) hold_req = 1'b1;
        send_cmd(random_cmd(), 1'b0, g_zero);
      end
    end

    settle();
    // keep watching to catch a stray result transfer
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/rltr_pkg.sv
src/rltr_time_table.sv
src/rltr_ring_mem.sv
src/rate_limited_trace_ring_top.sv
verif/tb_top.sv
